### rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg: shared constants and types for the bounded byte stream FIFO
// Sizes, operation kinds, command/response records and the control bundles
// passed between the front queue, the engine and the response queue.
// ----------------------------------------------------------------------------
package bbf_pkg;

  // Storage sizing
  localparam int DEPTH       = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int LEN_W       = $clog2(MAX_REQUEST + 1);

  // Fixed field widths of the channels
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 7;
  localparam int OCC_W   = 11;
  localparam int CAP_W   = 11;
  localparam int TOTAL_W = 64;

  // Register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Operation kinds; unused codes are classified as a status-only request
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_PEEK  = 3'd1,
    OP_POP   = 3'd2,
    OP_READ  = 3'd3,
    OP_END   = 3'd4,
    OP_NOP   = 3'd7
  } op_t;

  // Classified command held between front and engine
  typedef struct packed {
    op_t               kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // One response transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last_of_run;
    logic               write_accepted;
    logic [OCC_W-1:0]   occupancy;
    logic [OCC_W-1:0]   room_left;
    logic               is_empty;
    logic               input_closed;
    logic               end_of_stream;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
  } rsp_t;

  // Response queue fill state seen by the engine for issue credit
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } rq_status_t;

  // Engine sequencer
  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

endpackage

### rtl/bbf_cmd_if.sv
// ----------------------------------------------------------------------------
// bbf_cmd_if: command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface bbf_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [bbf_pkg::OP_W-1:0]  op;
  logic [bbf_pkg::BYTE_W-1:0] write_byte;
  logic [bbf_pkg::REQ_W-1:0] request_length;

  modport source (output valid, output op, output write_byte, output request_length,
                  input ready);
  modport sink   (input valid, input op, input write_byte, input request_length,
                  output ready);
endinterface

### rtl/bbf_rsp_if.sv
// ----------------------------------------------------------------------------
// bbf_rsp_if: response channel
// Valid/ready channel carrying one response transaction with status.
// ----------------------------------------------------------------------------
interface bbf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bbf_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_valid;
  logic                         last_of_run;
  logic                         write_accepted;
  logic [bbf_pkg::OCC_W-1:0]    occupancy;
  logic [bbf_pkg::OCC_W-1:0]    room_left;
  logic                         is_empty;
  logic                         input_closed;
  logic                         end_of_stream;
  logic [bbf_pkg::TOTAL_W-1:0]  total_written;
  logic [bbf_pkg::TOTAL_W-1:0]  total_read;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output write_accepted, output occupancy, output room_left,
                  output is_empty, output input_closed, output end_of_stream,
                  output total_written, output total_read, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                  input write_accepted, input occupancy, input room_left,
                  input is_empty, input input_closed, input end_of_stream,
                  input total_written, input total_read, output ready);
endinterface

### rtl/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front: command intake
// Accepts command transactions, decodes the operation, caps the requested
// length and holds them in a two-entry queue ahead of the engine.
// ----------------------------------------------------------------------------
module bbf_front (
  input  logic            clk,
  input  logic            rst,
  bbf_cmd_if.sink         cmd,
  output logic            q_valid,
  output bbf_pkg::cmd_t   q_cmd,
  input  logic            q_ready
);

  localparam int RW = bbf_pkg::REQ_W;
  localparam int LW = bbf_pkg::LEN_W;

  bbf_pkg::cmd_t slot [2];
  bbf_pkg::cmd_t decoded;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign cmd.ready = (count != 2'd2);
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = slot[rd_ptr];
  assign push      = cmd.valid && cmd.ready;
  assign pop       = q_valid && q_ready;

  // Decode operation and cap request length
  always_comb begin
    case (cmd.op)
      bbf_pkg::OP_WRITE: decoded.kind = bbf_pkg::OP_WRITE;
      bbf_pkg::OP_PEEK:  decoded.kind = bbf_pkg::OP_PEEK;
      bbf_pkg::OP_POP:   decoded.kind = bbf_pkg::OP_POP;
      bbf_pkg::OP_READ:  decoded.kind = bbf_pkg::OP_READ;
      bbf_pkg::OP_END:   decoded.kind = bbf_pkg::OP_END;
      default:           decoded.kind = bbf_pkg::OP_NOP;
    endcase
    decoded.data = cmd.write_byte;
    if (cmd.request_length > RW'(bbf_pkg::MAX_REQUEST)) begin
      decoded.len = LW'(bbf_pkg::MAX_REQUEST);
    end else begin
      decoded.len = LW'(cmd.request_length);
    end
  end

  // Queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= decoded;
  end

endmodule

### rtl/bbf_engine.sv
// ----------------------------------------------------------------------------
// bbf_engine: byte store and command execution
// Owns the circular byte store, pointers, counters and totals. Executes one
// command at a time; peek and read stream one byte per cycle, while the
// response queue has room, through the store's registered read port.
// ----------------------------------------------------------------------------
module bbf_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  bbf_pkg::cmd_t                 cmd,
  output logic                          cmd_ready,
  input  logic [bbf_pkg::CAP_W-1:0]     cap_cfg,
  input  bbf_pkg::rq_status_t           rq_status,
  output logic                          push,
  output bbf_pkg::rsp_t                 push_rsp
);

  localparam int PW = bbf_pkg::PTR_W;
  localparam int CW = bbf_pkg::CNT_W;
  localparam int SW = bbf_pkg::CNT_W + 1;
  localparam int LW = bbf_pkg::LEN_W;
  localparam int BW = bbf_pkg::BYTE_W;
  localparam int TW = bbf_pkg::TOTAL_W;
  localparam int OW = bbf_pkg::OCC_W;
  localparam int KW = bbf_pkg::CAP_W;

  // Circular pointer advance, inc never exceeds the store depth
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                            input logic [CW-1:0] inc);
    logic [SW-1:0] sum;
    sum = SW'(p) + SW'(inc);
    if (sum >= SW'(bbf_pkg::DEPTH)) sum = sum - SW'(bbf_pkg::DEPTH);
    return sum[PW-1:0];
  endfunction

  logic [BW-1:0]       mem [bbf_pkg::DEPTH];
  logic [BW-1:0]       rdata;

  bbf_pkg::eng_state_t state, state_next;
  logic [PW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [TW-1:0]       wtotal, wtotal_next;
  logic [TW-1:0]       rtotal, rtotal_next;
  logic                ended, ended_next;
  logic [PW-1:0]       run_addr, run_addr_next;
  logic [LW-1:0]       run_left, run_left_next;
  logic                s1_valid;
  bbf_pkg::rsp_t       s1_meta;
  bbf_pkg::rsp_t       meta_next;

  logic [CW-1:0]       cap;
  logic [CW-1:0]       room_next;
  logic [LW-1:0]       n;
  logic                can_issue;
  logic                issue;
  logic                is_stream;
  logic                rd_en;
  logic [PW-1:0]       rd_addr;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic                bv;
  logic                last;
  logic                acc;

  // Effective capacity and run length
  assign cap = (cap_cfg > KW'(bbf_pkg::DEPTH)) ? CW'(bbf_pkg::DEPTH) : CW'(cap_cfg);
  assign n   = (CW'(cmd.len) < count) ? cmd.len : LW'(count);
  assign is_stream = (cmd.kind == bbf_pkg::OP_PEEK) || (cmd.kind == bbf_pkg::OP_READ);

  // Issue credit: the result issued now must fit the response queue next cycle
  assign can_issue = ({1'b0, rq_status.count} + {2'b00, s1_valid})
                     < (3'd2 + {2'b00, rq_status.pop});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bbf_pkg::ENG_IDLE: begin
        if (cmd_valid && can_issue && is_stream && (n > LW'(1))) begin
          state_next = bbf_pkg::ENG_RUN;
        end
      end
      bbf_pkg::ENG_RUN: begin
        if (can_issue && (run_left == LW'(1))) state_next = bbf_pkg::ENG_IDLE;
      end
      default: state_next = bbf_pkg::ENG_IDLE;
    endcase
  end

  // Datapath control and state updates
  always_comb begin
    cmd_ready     = 1'b0;
    issue         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = run_addr;
    wr_en         = 1'b0;
    wr_addr       = ptr_add(head, count);
    head_next     = head;
    count_next    = count;
    wtotal_next   = wtotal;
    rtotal_next   = rtotal;
    ended_next    = ended;
    run_addr_next = run_addr;
    run_left_next = run_left;
    bv            = 1'b0;
    last          = 1'b1;
    acc           = 1'b0;
    case (state)
      bbf_pkg::ENG_IDLE: begin
        if (cmd_valid && can_issue) begin
          cmd_ready = 1'b1;
          issue     = 1'b1;
          case (cmd.kind)
            bbf_pkg::OP_WRITE: begin
              if (count < cap) begin
                wr_en       = 1'b1;
                acc         = 1'b1;
                count_next  = count + CW'(1);
                wtotal_next = wtotal + TW'(1);
              end
            end
            bbf_pkg::OP_PEEK, bbf_pkg::OP_READ: begin
              if (n != '0) begin
                rd_en         = 1'b1;
                rd_addr       = head;
                bv            = 1'b1;
                last          = (n == LW'(1));
                run_addr_next = ptr_add(head, CW'(1));
                run_left_next = n - LW'(1);
              end
              if (cmd.kind == bbf_pkg::OP_READ) begin
                head_next   = ptr_add(head, CW'(n));
                count_next  = count - CW'(n);
                rtotal_next = rtotal + TW'(n);
              end
            end
            bbf_pkg::OP_POP: begin
              head_next   = ptr_add(head, CW'(n));
              count_next  = count - CW'(n);
              rtotal_next = rtotal + TW'(n);
            end
            bbf_pkg::OP_END: ended_next = 1'b1;
            default: ;
          endcase
        end
      end
      bbf_pkg::ENG_RUN: begin
        if (can_issue) begin
          issue         = 1'b1;
          rd_en         = 1'b1;
          bv            = 1'b1;
          last          = (run_left == LW'(1));
          run_addr_next = ptr_add(run_addr, CW'(1));
          run_left_next = run_left - LW'(1);
        end
      end
      default: ;
    endcase
  end

  // Status after the whole command
  assign room_next = (cap > count_next) ? (cap - count_next) : '0;

  always_comb begin
    meta_next.out_byte       = '0;
    meta_next.byte_valid     = bv;
    meta_next.last_of_run    = last;
    meta_next.write_accepted = acc;
    meta_next.occupancy      = OW'(count_next);
    meta_next.room_left      = OW'(room_next);
    meta_next.is_empty       = (count_next == '0);
    meta_next.input_closed   = ended_next;
    meta_next.end_of_stream  = ended_next && (count_next == '0);
    meta_next.total_written  = wtotal_next;
    meta_next.total_read     = rtotal_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bbf_pkg::ENG_IDLE;
      head     <= '0;
      count    <= '0;
      wtotal   <= '0;
      rtotal   <= '0;
      ended    <= 1'b0;
      run_left <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      wtotal   <= wtotal_next;
      rtotal   <= rtotal_next;
      ended    <= ended_next;
      run_left <= run_left_next;
      s1_valid <= issue;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_addr <= run_addr_next;
    if (issue) s1_meta <= meta_next;
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Merge read data into the staged result
  assign push = s1_valid;
  always_comb begin
    push_rsp          = s1_meta;
    push_rsp.out_byte = s1_meta.byte_valid ? rdata : '0;
  end

endmodule

### rtl/bbf_rsp_queue.sv
// ----------------------------------------------------------------------------
// bbf_rsp_queue: response output queue
// Two-entry queue that decouples the engine from a stalling response sink
// and reports its fill state back for issue credit.
// ----------------------------------------------------------------------------
module bbf_rsp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bbf_pkg::rsp_t        push_rsp,
  output bbf_pkg::rq_status_t  status,
  bbf_rsp_if.source            rsp
);

  bbf_pkg::rsp_t slot [2];
  bbf_pkg::rsp_t head_rsp;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop          = rsp.valid && rsp.ready;
  assign status.count = count;
  assign status.pop   = pop;

  // Queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_rsp;
  end

  // Drive the response channel from the oldest entry
  assign head_rsp           = slot[rd_ptr];
  assign rsp.valid          = (count != 2'd0);
  assign rsp.out_byte       = head_rsp.out_byte;
  assign rsp.byte_valid     = head_rsp.byte_valid;
  assign rsp.last_of_run    = head_rsp.last_of_run;
  assign rsp.write_accepted = head_rsp.write_accepted;
  assign rsp.occupancy      = head_rsp.occupancy;
  assign rsp.room_left      = head_rsp.room_left;
  assign rsp.is_empty       = head_rsp.is_empty;
  assign rsp.input_closed   = head_rsp.input_closed;
  assign rsp.end_of_stream  = head_rsp.end_of_stream;
  assign rsp.total_written  = head_rsp.total_written;
  assign rsp.total_read     = head_rsp.total_read;

endmodule

### rtl/bounded_byte_stream_fifo.sv
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo: byte FIFO with run-time capacity limit
// Byte writes, peek/read/pop runs of up to 64 bytes and an end-of-input
// flag; every response carries occupancy, room and running totals.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    op, write_byte, request_length
//   rsp      out  valid/ready    out_byte .. total_read (11 fields)
//   apb      in   psel/penable   capacity_in_use at byte address 0
//
// Write, pop, end input, unused ops and empty peek/read: one response each.
// Peek/read of n bytes: n responses, one byte per cycle while the response
// queue has room, from the store's single registered read port; the next
// command waits until the run ends. A response passes the front queue slot,
// store read stage and response queue slot, and waits there until taken.
// Reset clears pointers, counters, totals and flags; store contents are
// left as they are. A stalled rsp sink backs up through the two queues.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
  input  logic                              clk,
  input  logic                              rst,
  bbf_cmd_if.sink                           cmd,
  bbf_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bbf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bbf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bbf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int DW = bbf_pkg::APB_DATA_W;
  localparam int AW = bbf_pkg::APB_ADDR_W;
  localparam int KW = bbf_pkg::CAP_W;

  logic                 cap_reg;
  logic [KW-1:0]        capacity;
  logic                 q_valid;
  bbf_pkg::cmd_t        q_cmd;
  logic                 q_ready;
  bbf_pkg::rq_status_t  rq_status;
  logic                 push;
  bbf_pkg::rsp_t        push_rsp;

  // Register select
  assign cap_reg = (paddr[AW-1:2] == bbf_pkg::REG_CAPACITY);
  assign pready  = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bbf_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && cap_reg) begin
      capacity <= pwdata[KW-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (cap_reg) prdata = DW'(capacity);
  end

  bbf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  bbf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .cap_cfg   (capacity),
    .rq_status (rq_status),
    .push      (push),
    .push_rsp  (push_rsp)
  );

  bbf_rsp_queue u_rsp_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rsp (push_rsp),
    .status   (rq_status),
    .rsp      (rsp)
  );

endmodule

### rtl/bbf_checker.sv
// ----------------------------------------------------------------------------
// bbf_checker: port-level checks for the bounded byte stream FIFO
// Watches the response channel for handshake and status consistency.
// ----------------------------------------------------------------------------
module bbf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bbf_pkg::BYTE_W-1:0]   out_byte,
  input logic                         byte_valid,
  input logic                         last_of_run,
  input logic                         write_accepted,
  input logic [bbf_pkg::OCC_W-1:0]    occupancy,
  input logic                         is_empty,
  input logic                         input_closed,
  input logic                         end_of_stream
);

  // A pending response transaction is not withdrawn
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped while stalled");

  // Status-only responses carry no byte and close their run
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !byte_valid |-> (out_byte == '0) && last_of_run)
    else $error("status-only response carries a byte or is not last");

  // Empty and end-of-stream flags agree with occupancy and closed flag
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (occupancy == '0)) &&
                  (end_of_stream == (input_closed && is_empty)))
    else $error("status flags inconsistent");

  // An accepted write never reports a delivered byte and never an empty store
  a_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && write_accepted |-> !byte_valid && !is_empty)
    else $error("accepted write response inconsistent");

endmodule

bind bounded_byte_stream_fifo bbf_checker u_bbf_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .out_byte       (rsp.out_byte),
  .byte_valid     (rsp.byte_valid),
  .last_of_run    (rsp.last_of_run),
  .write_accepted (rsp.write_accepted),
  .occupancy      (rsp.occupancy),
  .is_empty       (rsp.is_empty),
  .input_closed   (rsp.input_closed),
  .end_of_stream  (rsp.end_of_stream)
);
